// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } res_t;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer, receive side.
// Input channel: stream_valid_i / stream_ready_o / stream_byte_i carries the
// raw frame stream, one byte per request. Header bytes, extended length
// (16 or 64 bit, big-endian) and the optional mask key are absorbed.
// Output channel: result_valid_o / result_ready_i with payload_byte_o,
// frame_last_o, frame_empty_o. Each payload byte leaves unmasked; the last
// byte of a frame has frame_last_o set. A zero-length frame yields a single
// request with frame_empty_o and frame_last_o set and payload_byte_o zero.
// Path: an accepted byte sits in the input register, is parsed combinationally
// once the result register can take its output, and its result is captured
// in the result register, which drives the outputs.
// Throughput: one byte per cycle unless the output stalls, fixed by the single
// input register feeding the parser and the single result register.
// Reset: parser returns to waiting for the first header byte; both register
// stages empty.
// Stall: while a result waits unaccepted, the input register holds one more
// byte; stream_ready_o drops once that register is also full.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       stream_valid_i,
  output logic       stream_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       result_valid_o,
  input  logic       result_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       frame_last_o,
  output logic       frame_empty_o
);
  import wsd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       fire;
  res_t       res;

  // parser consumes the held byte whenever the result slot can take its output
  assign fire           = in_valid_q && advance;
  assign stream_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stream_ready_o) begin
      in_valid_q <= stream_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_ready_o && stream_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  wsd_result_reg u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .ready_i   (result_ready_i),
    .advance_o (advance),
    .valid_o   (result_valid_o),
    .data_o    (payload_byte_o),
    .last_o    (frame_last_o),
    .empty_o   (frame_empty_o)
  );

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  output wsd_pkg::res_t res_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_q, ext_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic        mask_q, mask_d;
  logic [1:0]  kidx_q, kidx_d;

  logic        len_done, len_mask, hdr_done;
  logic [63:0] hdr_rem, rem_new;
  logic [3:0]  ext_new;
  logic [1:0]  kidx_inc;
  logic [7:0]  key_byte;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      ext_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      mask_q  <= 1'b0;
      kidx_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ext_q   <= ext_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      mask_q  <= mask_d;
      kidx_q  <= kidx_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    ext_d    = ext_q;
    rem_d    = rem_q;
    key_d    = key_q;
    mask_d   = mask_q;
    kidx_d   = kidx_q;
    len_done = 1'b0;
    len_mask = mask_q;
    hdr_done = 1'b0;
    hdr_rem  = rem_q;
    rem_new  = {rem_q[55:0], byte_i};
    ext_new  = (ext_q != 4'd0) ? ext_q - 4'd1 : 4'd0;
    kidx_inc = kidx_q + 2'd1;
    key_byte = 8'h00;
    res      = '0;

    case (phase_q)
      PH_HDR1: begin
        mask_d   = byte_i[7];
        len_mask = byte_i[7];
        rem_d    = '0;
        if (byte_i[6:0] == LEN_EXT16) begin
          ext_d   = EXT16_BYTES;
          phase_d = PH_EXT;
        end else if (byte_i[6:0] == LEN_EXT64) begin
          ext_d   = EXT64_BYTES;
          phase_d = PH_EXT;
        end else begin
          rem_d    = 64'(byte_i[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        rem_d = rem_new;
        ext_d = ext_new;
        if (ext_new == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], byte_i};
        kidx_d = kidx_inc;
        if (kidx_inc == 2'd0) begin
          hdr_done = 1'b1;
          hdr_rem  = rem_q;
        end
      end
      PH_DATA: begin
        if (mask_q) begin
          case (kidx_q)
            2'd0:    key_byte = key_q[31:24];
            2'd1:    key_byte = key_q[23:16];
            2'd2:    key_byte = key_q[15:8];
            default: key_byte = key_q[7:0];
          endcase
        end
        kidx_d    = kidx_inc;
        rem_d     = rem_q - 64'd1;
        res.valid = 1'b1;
        res.data  = byte_i ^ key_byte;
        if (rem_q == 64'd1) begin
          res.last = 1'b1;
          phase_d  = PH_HDR0;
          kidx_d   = '0;
        end
      end
      default: begin
        // first header byte: FIN, RSV, opcode dropped
        phase_d = PH_HDR1;
      end
    endcase

    if (len_done) begin
      key_d = '0;
      if (len_mask) begin
        phase_d = PH_KEY;
        kidx_d  = '0;
      end else begin
        hdr_done = 1'b1;
        hdr_rem  = rem_d;
      end
    end

    if (hdr_done) begin
      kidx_d = '0;
      if (hdr_rem == 64'd0) begin
        phase_d   = PH_HDR0;
        res.valid = 1'b1;
        res.data  = 8'h00;
        res.last  = 1'b1;
        res.empty = 1'b1;
      end else begin
        phase_d = PH_DATA;
      end
    end

    res_o       = res;
    res_o.valid = res.valid & fire_i;
  end

endmodule

// ===== rtl/wsd_result_reg.sv =====
module wsd_result_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          advance_o,
  output logic          valid_o,
  output logic [7:0]    data_o,
  output logic          last_o,
  output logic          empty_o
);
  import wsd_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q, empty_q;

  // slot may be refilled when empty or being drained this cycle
  assign advance_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      data_q  <= res_i.data;
      last_q  <= res_i.last;
      empty_q <= res_i.empty;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;
  assign empty_o = empty_q;

endmodule

// ===== rtl/wsd_checker.sv =====
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       stream_valid_i,
  input logic       stream_ready_o,
  input logic [7:0] stream_byte_i,
  input logic       result_valid_o,
  input logic       result_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       frame_last_o,
  input logic       frame_empty_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(payload_byte_o)
      && $stable(frame_last_o) && $stable(frame_empty_o))
    else $error("result dropped or changed under stall");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && frame_empty_o |-> frame_last_o && (payload_byte_o == 8'h00))
    else $error("empty frame result malformed");

  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> stream_ready_o)
    else $error("input stalled with no pending result");

  a_stream_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_valid_i && !stream_ready_o |=> stream_valid_i && $stable(stream_byte_i))
    else $error("stream request dropped or changed while stalled");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
